// ===== rtl/config_text_tokenizer_unit_defines.svh =====
// Assertion macros shared by the tokenizer RTL.
// No dependencies; included by the modules that carry checks.
`ifndef CONFIG_TEXT_TOKENIZER_UNIT_DEFINES_SVH
`define CONFIG_TEXT_TOKENIZER_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define CTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Expression must never be true outside reset.
`define CTT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ===== rtl/ctt_pkg.sv =====
// Types, codes and character classes for the configuration text tokenizer.
// No dependencies.
`default_nettype none

package ctt_pkg;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned ResIdxW = $clog2(MaxRes);

  typedef enum logic [2:0] {
    EV_CHAR    = 3'd0,
    EV_END     = 3'd1,
    EV_INVALID = 3'd2,
    EV_UNTERM  = 3'd3,
    EV_DONE    = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    K_NEWLINE = 3'd0,
    K_EQUALS  = 3'd1,
    K_COMMA   = 3'd2,
    K_STRING  = 3'd3,
    K_IDENT   = 3'd4,
    K_NUMBER  = 3'd5
  } kind_e;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef struct packed {
    event_e     ev;
    kind_e      kind;
    logic [7:0] ch;
    logic       first;
  } res_t;

  // All results caused by one input character; last_idx is count minus one.
  typedef struct packed {
    res_t [MaxRes-1:0]  res;
    logic [ResIdxW-1:0] last_idx;
  } bundle_t;

  function automatic res_t mk_res(event_e ev, kind_e kind, logic [7:0] ch, logic first);
    res_t r;
    r.ev    = ev;
    r.kind  = kind;
    r.ch    = ch;
    r.first = first;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_BSLASH) || (c == CH_DASH) || (c == CH_USCORE) ||
           (c == CH_AT) || (c == CH_DOT);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/config_text_tokenizer_unit.sv =====
// Configuration text tokenizer: one character in, token events out.
// Uses the usual valid/stall handshake on both sides; the sender holds valid and
// payload while in_stall_o is high. Each accepted character (char_in_i, with
// end_of_buffer_i on the last one) yields zero to four result transactions;
// last_result_o marks the final one belonging to that character.
// The first result of a character passes through the bundle queue, the
// sequencer's bundle register and the output register. Throughput: the front
// end takes one character per cycle while the queue is not full; the result
// sequencer emits one result per cycle while the output is not stalled. A
// two-entry bundle queue sits between them.
// When the receiver raises out_stall_i, the output
// register holds, the sequencer stops, the queue fills and in_stall_o rises.
// Reset puts the lexer in idle mode, empties the queue and drops out_valid_o.
// Depends on ctt_pkg, ctt_front, ctt_queue and ctt_back.
`default_nettype none

module config_text_tokenizer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_in_i,
  input  wire logic       end_of_buffer_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      event_res_o,
  output logic [2:0]      token_kind_o,
  output logic [7:0]      char_value_o,
  output logic            first_of_token_o,
  output logic            last_result_o
);
  import ctt_pkg::*;

  logic    q_push, q_full, q_pop, q_empty;
  bundle_t q_wdata, q_rdata;

  ctt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .char_in_i       (char_in_i),
    .end_of_buffer_i (end_of_buffer_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata)
  );

  ctt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .empty_o     (q_empty)
  );

  ctt_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_data_i         (q_rdata),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_res_o      (event_res_o),
    .token_kind_o     (token_kind_o),
    .char_value_o     (char_value_o),
    .first_of_token_o (first_of_token_o),
    .last_result_o    (last_result_o)
  );

endmodule

`default_nettype wire

// ===== rtl/ctt_front.sv =====
// Front end: accepts characters, keeps the lexer mode and builds the
// result bundle for each character. Depends on ctt_pkg.
`default_nettype none

module ctt_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       char_in_i,
  input  wire logic             end_of_buffer_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output ctt_pkg::bundle_t      q_data_o
);
  import ctt_pkg::*;

  typedef enum logic [5:0] {
    M_IDLE    = 6'b000001,
    M_IDENT   = 6'b000010,
    M_NUMBER  = 6'b000100,
    M_STRING  = 6'b001000,
    M_COMMENT = 6'b010000,
    M_ERROR   = 6'b100000
  } mode_e;

  mode_e mode_q, mode_d;
  logic  qdbl_q, qdbl_d;
  logic  has_ch_q, has_ch_d;

  res_t [MaxRes-1:0] res;
  logic [ResIdxW:0]  n;
  logic              fresh;
  logic              accept;
  logic [7:0]        c;

  assign c          = char_in_i;
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    mode_d   = mode_q;
    qdbl_d   = qdbl_q;
    has_ch_d = has_ch_q;
    res      = '0;
    n        = '0;
    fresh    = 1'b0;

    unique case (mode_q)
      M_IDENT: begin
        if (is_ident(c) || is_digit(c)) begin
          res[n[ResIdxW-1:0]] = mk_res(EV_CHAR, K_IDENT, c, 1'b0);
          n = n + 1'b1;
        end else begin
          res[n[ResIdxW-1:0]] = mk_res(EV_END, K_IDENT, 8'h00, 1'b0);
          n = n + 1'b1;
          mode_d = M_IDLE;
          fresh  = 1'b1;
        end
      end
      M_NUMBER: begin
        if (is_digit(c)) begin
          res[n[ResIdxW-1:0]] = mk_res(EV_CHAR, K_NUMBER, c, 1'b0);
          n = n + 1'b1;
        end else begin
          res[n[ResIdxW-1:0]] = mk_res(EV_END, K_NUMBER, 8'h00, 1'b0);
          n = n + 1'b1;
          mode_d = M_IDLE;
          fresh  = 1'b1;
        end
      end
      M_STRING: begin
        if (c == (qdbl_q ? CH_DQUOTE : CH_SQUOTE)) begin
          res[n[ResIdxW-1:0]] = mk_res(EV_END, K_STRING, 8'h00, 1'b0);
          n = n + 1'b1;
          mode_d   = M_IDLE;
          has_ch_d = 1'b0;
        end else begin
          res[n[ResIdxW-1:0]] = mk_res(EV_CHAR, K_STRING, c, !has_ch_q);
          n = n + 1'b1;
          has_ch_d = 1'b1;
        end
      end
      M_COMMENT: begin
        if (c == CH_NL) mode_d = M_IDLE;
      end
      M_ERROR: begin
        mode_d = M_ERROR;
      end
      default: begin
        mode_d = M_IDLE;
        fresh  = 1'b1;
      end
    endcase

    // character lexed from idle, possibly right after closing a token
    if (fresh && !is_space(c)) begin
      if (c == CH_SEMI) begin
        mode_d = M_COMMENT;
      end else if (c == CH_NL) begin
        res[n[ResIdxW-1:0]] = mk_res(EV_CHAR, K_NEWLINE, c, 1'b1);
        n = n + 1'b1;
        res[n[ResIdxW-1:0]] = mk_res(EV_END, K_NEWLINE, 8'h00, 1'b0);
        n = n + 1'b1;
      end else if (c == CH_EQUALS) begin
        res[n[ResIdxW-1:0]] = mk_res(EV_CHAR, K_EQUALS, c, 1'b1);
        n = n + 1'b1;
        res[n[ResIdxW-1:0]] = mk_res(EV_END, K_EQUALS, 8'h00, 1'b0);
        n = n + 1'b1;
      end else if (c == CH_COMMA) begin
        res[n[ResIdxW-1:0]] = mk_res(EV_CHAR, K_COMMA, c, 1'b1);
        n = n + 1'b1;
        res[n[ResIdxW-1:0]] = mk_res(EV_END, K_COMMA, 8'h00, 1'b0);
        n = n + 1'b1;
      end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
        mode_d   = M_STRING;
        qdbl_d   = (c == CH_DQUOTE);
        has_ch_d = 1'b0;
      end else if (is_ident(c)) begin
        res[n[ResIdxW-1:0]] = mk_res(EV_CHAR, K_IDENT, c, 1'b1);
        n = n + 1'b1;
        mode_d = M_IDENT;
      end else if (is_digit(c)) begin
        res[n[ResIdxW-1:0]] = mk_res(EV_CHAR, K_NUMBER, c, 1'b1);
        n = n + 1'b1;
        mode_d = M_NUMBER;
      end else begin
        res[n[ResIdxW-1:0]] = mk_res(EV_INVALID, K_NEWLINE, 8'h00, 1'b0);
        n = n + 1'b1;
        mode_d = M_ERROR;
      end
    end

    if (end_of_buffer_i) begin
      if (mode_d == M_STRING) begin
        res[n[ResIdxW-1:0]] = mk_res(EV_UNTERM, K_NEWLINE, 8'h00, 1'b0);
        n = n + 1'b1;
      end else if (mode_d != M_ERROR) begin
        if (mode_d == M_IDENT) begin
          res[n[ResIdxW-1:0]] = mk_res(EV_END, K_IDENT, 8'h00, 1'b0);
          n = n + 1'b1;
        end else if (mode_d == M_NUMBER) begin
          res[n[ResIdxW-1:0]] = mk_res(EV_END, K_NUMBER, 8'h00, 1'b0);
          n = n + 1'b1;
        end
        res[n[ResIdxW-1:0]] = mk_res(EV_DONE, K_NEWLINE, 8'h00, 1'b0);
        n = n + 1'b1;
      end
      mode_d   = M_IDLE;
      qdbl_d   = 1'b0;
      has_ch_d = 1'b0;
    end
  end

  assign q_push_o          = accept && (n != '0);
  assign q_data_o.res      = res;
  assign q_data_o.last_idx = n[ResIdxW-1:0] - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      qdbl_q   <= 1'b0;
      has_ch_q <= 1'b0;
    end else if (accept) begin
      mode_q   <= mode_d;
      qdbl_q   <= qdbl_d;
      has_ch_q <= has_ch_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ctt_queue.sv =====
// Two-entry bundle queue between the lexer front end and the result sequencer.
// Depends on ctt_pkg and the assertion macro header.
`default_nettype none
`include "config_text_tokenizer_unit_defines.svh"

module ctt_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire ctt_pkg::bundle_t push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output ctt_pkg::bundle_t      pop_data_o,
  output logic                  empty_o
);
  import ctt_pkg::*;

  bundle_t [1:0] mem_q;
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 2'd1;
    else if (!push_i && pop_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  `CTT_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `CTT_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `CTT_ASSERT_IMP(a_ptr_count, clk_i, rst_ni, (count_q == 2'd0) || (count_q == 2'd2),
                  wr_ptr_q == rd_ptr_q, "queue pointers disagree with fill count")

endmodule

`default_nettype wire

// ===== rtl/ctt_back.sv =====
// Result sequencer: unpacks one bundle at a time into single results
// behind an output register. Depends on ctt_pkg and the assertion macro header.
`default_nettype none
`include "config_text_tokenizer_unit_defines.svh"

module ctt_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire ctt_pkg::bundle_t q_data_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [2:0]            event_res_o,
  output logic [2:0]            token_kind_o,
  output logic [7:0]            char_value_o,
  output logic                  first_of_token_o,
  output logic                  last_result_o
);
  import ctt_pkg::*;

  bundle_t            bundle_q;
  logic               busy_q, busy_d;
  logic [ResIdxW-1:0] idx_q;
  logic               slot_free, emit, at_last;

  res_t out_res_q;
  logic out_last_q;
  logic out_valid_q;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign at_last   = (idx_q == bundle_q.last_idx);
  assign emit      = busy_q && slot_free;
  assign q_pop_o   = !q_empty_i && (!busy_q || (emit && at_last));

  always_comb begin
    busy_d = busy_q;
    if (q_pop_o) busy_d = 1'b1;
    else if (emit && at_last) busy_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (q_pop_o) idx_q <= '0;
      else if (emit) idx_q <= idx_q + 1'b1;
      if (slot_free) out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) bundle_q <= q_data_i;
    if (emit) begin
      out_res_q  <= bundle_q.res[idx_q];
      out_last_q <= at_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = out_res_q.ev;
  assign token_kind_o     = out_res_q.kind;
  assign char_value_o     = out_res_q.ch;
  assign first_of_token_o = out_res_q.first;
  assign last_result_o    = out_last_q;

  `CTT_ASSERT_IMP(a_idx_range, clk_i, rst_ni, busy_q, idx_q <= bundle_q.last_idx,
                  "result index past end of bundle")
  `CTT_ASSERT_NEVER(a_pop_mid_bundle, clk_i, rst_ni, q_pop_o && busy_q && !(emit && at_last),
                    "bundle replaced before all results sent")

endmodule

`default_nettype wire

// ===== test/tb_config_text_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// Testbench for config_text_tokenizer_unit: directed and random configuration text,
// every result transaction checked against a lexer model kept in the bench.
// Depends on ctt_pkg and the tokenizer RTL.

module tb_config_text_tokenizer_unit;
  import ctt_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_IDENT,
    MD_NUMBER,
    MD_STRING,
    MD_COMMENT,
    MD_ERROR
  } lex_mode_e;

  typedef struct {
    event_e     ev;
    kind_e      kind;
    logic [7:0] ch;
    logic       first;
    logic       last;
  } tok_evt_t;

  logic       clk_i;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic [7:0] char_in_i       = 8'h00;
  logic       end_of_buffer_i = 1'b0;
  logic       out_stall_i     = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [2:0] event_res_o;
  logic [2:0] token_kind_o;
  logic [7:0] char_value_o;
  logic       first_of_token_o;
  logic       last_result_o;

  tok_evt_t     pending_evts[$];  // expected result transactions, oldest first
  tok_evt_t     step_evts[$];     // results of the character being lexed
  byte unsigned text_q[$];

  lex_mode_e   mdl_mode     = MD_IDLE;
  logic        mdl_dquote   = 1'b0;
  logic        mdl_str_open = 1'b0;

  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_count  = 0;

  config_text_tokenizer_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_in_i        (char_in_i),
    .end_of_buffer_i  (end_of_buffer_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_res_o      (event_res_o),
    .token_kind_o     (token_kind_o),
    .char_value_o     (char_value_o),
    .first_of_token_o (first_of_token_o),
    .last_result_o    (last_result_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------- lexer model

  function automatic bit blank_char(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit word_char(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           (c == CH_BSLASH) || (c == CH_DASH) || (c == CH_USCORE) ||
           (c == CH_AT) || (c == CH_DOT);
  endfunction

  function automatic void add_evt(event_e ev, kind_e kind, logic [7:0] ch, logic first);
    tok_evt_t e;
    e.ev    = ev;
    e.kind  = kind;
    e.ch    = ch;
    e.first = first;
    e.last  = 1'b0;
    step_evts.push_back(e);
  endfunction

  // Character seen from idle mode.
  function automatic void open_token(logic [7:0] c);
    kind_e k;
    if (c == CH_SEMI) begin
      mdl_mode = MD_COMMENT;
    end else if ((c == CH_NL) || (c == CH_EQUALS) || (c == CH_COMMA)) begin
      k = K_COMMA;
      if (c == CH_NL) k = K_NEWLINE;
      else if (c == CH_EQUALS) k = K_EQUALS;
      add_evt(EV_CHAR, k, c, 1'b1);
      add_evt(EV_END, k, 8'h00, 1'b0);
    end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
      mdl_mode     = MD_STRING;
      mdl_dquote   = (c == CH_DQUOTE);
      mdl_str_open = 1'b0;
    end else if (word_char(c)) begin
      add_evt(EV_CHAR, K_IDENT, c, 1'b1);
      mdl_mode = MD_IDENT;
    end else if (digit_char(c)) begin
      add_evt(EV_CHAR, K_NUMBER, c, 1'b1);
      mdl_mode = MD_NUMBER;
    end else if (!blank_char(c)) begin
      add_evt(EV_INVALID, K_NEWLINE, 8'h00, 1'b0);
      mdl_mode = MD_ERROR;
    end
  endfunction

  function automatic void lex_char(logic [7:0] c, logic eob);
    tok_evt_t e;
    step_evts.delete();
    case (mdl_mode)
      MD_IDENT: begin
        if (word_char(c) || digit_char(c)) begin
          add_evt(EV_CHAR, K_IDENT, c, 1'b0);
        end else begin
          add_evt(EV_END, K_IDENT, 8'h00, 1'b0);
          mdl_mode = MD_IDLE;
          open_token(c);
        end
      end
      MD_NUMBER: begin
        if (digit_char(c)) begin
          add_evt(EV_CHAR, K_NUMBER, c, 1'b0);
        end else begin
          add_evt(EV_END, K_NUMBER, 8'h00, 1'b0);
          mdl_mode = MD_IDLE;
          open_token(c);
        end
      end
      MD_STRING: begin
        if (c == (mdl_dquote ? CH_DQUOTE : CH_SQUOTE)) begin
          add_evt(EV_END, K_STRING, 8'h00, 1'b0);
          mdl_mode     = MD_IDLE;
          mdl_str_open = 1'b0;
        end else begin
          add_evt(EV_CHAR, K_STRING, c, !mdl_str_open);
          mdl_str_open = 1'b1;
        end
      end
      MD_COMMENT: begin
        if (c == CH_NL) mdl_mode = MD_IDLE;
      end
      MD_ERROR: begin
      end
      default: begin
        mdl_mode = MD_IDLE;
        open_token(c);
      end
    endcase
    if (eob) begin
      if (mdl_mode == MD_STRING) begin
        add_evt(EV_UNTERM, K_NEWLINE, 8'h00, 1'b0);
      end else if (mdl_mode != MD_ERROR) begin
        if (mdl_mode == MD_IDENT) add_evt(EV_END, K_IDENT, 8'h00, 1'b0);
        else if (mdl_mode == MD_NUMBER) add_evt(EV_END, K_NUMBER, 8'h00, 1'b0);
        add_evt(EV_DONE, K_NEWLINE, 8'h00, 1'b0);
      end
      mdl_mode     = MD_IDLE;
      mdl_dquote   = 1'b0;
      mdl_str_open = 1'b0;
    end
    if (step_evts.size() != 0) begin
      e      = step_evts.pop_back();
      e.last = 1'b1;
      step_evts.push_back(e);
    end
    foreach (step_evts[i]) pending_evts.push_back(step_evts[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic send_char(logic [7:0] c, logic eob);
    while ((idle_pct != 0) && ($urandom_range(0, 99) < idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    sent_count++;
    in_valid_i      <= 1'b1;
    char_in_i       <= c;
    end_of_buffer_i <= eob;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    lex_char(c, eob);
  endtask

  task automatic send_text(string s, bit eob_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], eob_at_end && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] rand_word_char(bit allow_digit);
    logic [7:0] specials [5] = '{CH_BSLASH, CH_DASH, CH_USCORE, CH_AT, CH_DOT};
    case ($urandom_range(0, allow_digit ? 9 : 7))
      0, 1, 2: return 8'h61 + 8'($urandom_range(0, 25));
      3, 4:    return 8'h41 + 8'($urandom_range(0, 25));
      5, 6, 7: return specials[$urandom_range(0, 4)];
      default: return 8'h30 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic void put_ident();
    text_q.push_back(rand_word_char(1'b0));
    repeat ($urandom_range(0, 5)) text_q.push_back(rand_word_char(1'b1));
  endfunction

  function automatic void put_number();
    repeat ($urandom_range(1, 4)) text_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void put_blank();
    logic [7:0] blanks [3] = '{CH_SPACE, CH_TAB, CH_CR};
    repeat ($urandom_range(0, 2)) text_q.push_back(blanks[$urandom_range(0, 2)]);
  endfunction

  function automatic void put_string();
    logic [7:0] q;
    logic [7:0] c;
    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
    text_q.push_back(q);
    repeat ($urandom_range(0, 4)) begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(32, 126));
      if (c == q) c = CH_SPACE;
      text_q.push_back(c);
    end
    text_q.push_back(q);
  endfunction

  function automatic void put_value();
    case ($urandom_range(0, 2))
      0:       put_ident();
      1:       put_number();
      default: put_string();
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_token_boundaries();
    // ident closed by '=', number closed by ',', empty string, newline with end of buffer
    send_text("k=7,\"\"\n", 1'b1);
  endtask

  task automatic test_comments_and_numbers();
    // comment swallows its newline; number still open at end of buffer
    send_text(";c\n 9", 1'b1);
  endtask

  task automatic test_string_edges();
    send_char(CH_SQUOTE, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);  // string left open at end of buffer
  endtask

  task automatic test_buffer_end();
    send_text(".=", 1'b1);   // four results on the last character
    send_char(CH_USCORE, 1'b0);
    send_char(CH_CR, 1'b1);  // trailing whitespace is not an error
    send_char(CH_SEMI, 1'b1);
  endtask

  task automatic test_invalid_chars();
    send_char("a", 1'b0);
    send_char(8'h80, 1'b0);
    send_char("b", 1'b0);
    send_char(CH_DQUOTE, 1'b1);
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_random_text(int unsigned n_items, int unsigned idle, int unsigned stall);
    int unsigned target;
    int unsigned pos;
    idle_pct  = idle;
    stall_pct = stall;
    target    = sent_count + n_items;
    while (sent_count < target) begin
      text_q.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 2)) begin
          put_blank();
          put_ident();
          put_blank();
          text_q.push_back(CH_EQUALS);
          put_blank();
          put_value();
          repeat ($urandom_range(0, 2)) begin
            text_q.push_back(CH_COMMA);
            put_blank();
            put_value();
          end
          put_blank();
          if ($urandom_range(0, 3) == 0) begin
            text_q.push_back(CH_SEMI);
            repeat ($urandom_range(0, 5)) text_q.push_back(8'($urandom_range(32, 126)));
          end
          text_q.push_back(CH_NL);
        end
        // often stop mid-token so the end of buffer meets an open token
        case ($urandom_range(0, 9))
          0: put_ident();
          1: put_number();
          2: put_blank();
          3: text_q.push_back(CH_SEMI);
          4: begin
            text_q.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
            text_q.push_back(rand_word_char(1'b1));
          end
          default: begin
          end
        endcase
        // broken text: one stray byte somewhere
        if ($urandom_range(0, 4) == 0) begin
          pos = $urandom_range(0, text_q.size() - 1);
          text_q.insert(pos, 8'($urandom_range(0, 255)));
        end
      end
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    end
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    tok_evt_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_evts.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction ev=%0d kind=%0d ch=%02h",
                                  event_res_o, token_kind_o, char_value_o));
      end else begin
        want = pending_evts.pop_front();
        if (event_res_o !== want.ev)
          report_mismatch($sformatf("event_res %0d, expected %0d", event_res_o, want.ev));
        if (token_kind_o !== want.kind)
          report_mismatch($sformatf("token_kind %0d, expected %0d", token_kind_o, want.kind));
        if (char_value_o !== want.ch)
          report_mismatch($sformatf("char_value %02h, expected %02h", char_value_o, want.ch));
        if (first_of_token_o !== want.first)
          report_mismatch($sformatf("first_of_token %0b, expected %0b",
                                    first_of_token_o, want.first));
        if (last_result_o !== want.last)
          report_mismatch($sformatf("last_result %0b, expected %0b", last_result_o, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_token_boundaries();
    test_comments_and_numbers();
    test_string_edges();
    test_buffer_end();
    test_invalid_chars();
    test_random_text(40, 0, 0);
    test_random_text(40, 48, 0);
    test_random_text(40, 0, 48);
    test_random_text(40, 34, 34);
    in_valid_i <= 1'b0;
    while (pending_evts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ctt_pkg.sv
rtl/ctt_front.sv
rtl/ctt_queue.sv
rtl/ctt_back.sv
rtl/config_text_tokenizer_unit.sv
test/tb_config_text_tokenizer_unit.sv
